// File: hdl/mnrb_pkg.sv
// Shared types and constants for the mesh neighbour route builder.
package mnrb_pkg;

    localparam int ChipW    = 16;
    localparam int CoreW    = 5;
    localparam int RouteW   = 24;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 9;
    localparam int LinkW    = 7;
    localparam int CoreBitBase = 7;

    typedef logic [ChipW-1:0]  t_chip;
    typedef logic [CoreW-1:0]  t_core;
    typedef logic [RouteW-1:0] t_route;
    typedef logic [LinkW-1:0]  t_link;
    typedef logic [CfgDataW-1:0] t_size;

    localparam logic [CfgIdxW-1:0] CFG_TOROID_MODE  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_ARRAY_WIDTH  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_ARRAY_HEIGHT = 2'd2;

    localparam t_link LINK_E = 7'd1;
    localparam t_link LINK_N = 7'd4;
    localparam t_link LINK_W = 7'd8;
    localparam t_link LINK_S = 7'd32;
    localparam t_link LINK_NONE = 7'd0;

    localparam t_size SIZE_MIN   = 9'd1;
    localparam t_size SIZE_MAX   = 9'd256;
    localparam t_size SIZE_RESET = 9'd2;

endpackage

// File: hdl/mnrb_req_if.sv
// Request channel: one chip id and core number per transaction.
interface mnrb_req_if import mnrb_pkg::*; ();
    logic  valid;
    logic  ready;
    t_chip chip_id;
    t_core core_number;

    modport source (output valid, output chip_id, output core_number, input ready);
    modport sink   (input valid, input chip_id, input core_number, output ready);
endinterface

// File: hdl/mnrb_rsp_if.sv
// Response channel: one multicast route entry per transaction.
interface mnrb_rsp_if import mnrb_pkg::*; ();
    logic   valid;
    logic   ready;
    t_chip  source_chip;
    t_core  source_core;
    t_route route_vector;
    logic   last_entry;

    modport source (output valid, output source_chip, output source_core,
                    output route_vector, output last_entry, input ready);
    modport sink   (input valid, input source_chip, input source_core,
                    input route_vector, input last_entry, output ready);
endinterface

// File: hdl/mesh_neighbour_route_builder.sv
// Mesh neighbour route builder: request in, one to four route entries out.
//
// Each request transaction (chip id, core 1..16) produces one route entry for
// a center core, two for an edge core and four for a corner core, delivered
// one per cycle while the response channel is ready, with last_entry set on
// the final one. Request acceptance leads to the first entry through three
// stages of a pipelined remainder unit (wrapping increment of the chip x and
// y coordinates, three restoring steps per stage), one stage that builds all
// entries, and the output serializer. The serializer sets the rate: it holds
// a request until all of its entries are taken, and the pipeline stages keep
// accepting requests while earlier entries wait on the response channel,
// until they fill. Array width and height written as 0 act as 1, above 256
// act as 256. Write configuration only while idle.
module mesh_neighbour_route_builder import mnrb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    mnrb_req_if.sink            i_req,
    mnrb_rsp_if.source          o_rsp
);

    // Remainder unit stages, then the entry build stage.
    localparam int ModStages = 3;
    localparam int NumStages = ModStages + 1;
    localparam int StepsPerStage = 3;

    typedef struct packed {
        t_chip chip;
        t_core core;
        t_size rx;      // (x + 1) mod width, in progress
        t_size ry;      // (y + 1) mod height, in progress
    } t_pipe;

    typedef struct packed {
        t_chip [3:0]  chip;
        t_route [3:0] route;
        t_core        core;
        logic [1:0]   cnt;  // number of entries minus one
    } t_build;

    // Three restoring remainder steps, highest shift first.
    function automatic t_size mod_steps(input t_size r, input t_size d, input int hi);
        logic [17:0] acc;
        logic [17:0] sh;
        acc = 18'(r);
        for (int k = 0; k < StepsPerStage; k++) begin
            sh = 18'(d) << (hi - k);
            if (acc >= sh) begin
                acc = acc - sh;
            end
        end
        return acc[CfgDataW-1:0];
    endfunction

    function automatic t_size eff_size(input t_size v);
        if (v == '0) begin
            return SIZE_MIN;
        end
        if (v > SIZE_MAX) begin
            return SIZE_MAX;
        end
        return v;
    endfunction

    // Configuration
    logic  r_toroid;
    t_size r_width;
    t_size r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toroid <= 1'b0;
            r_width  <= SIZE_RESET;
            r_height <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TOROID_MODE:  r_toroid <= i_cfg_data[0];
                CFG_ARRAY_WIDTH:  r_width  <= eff_size(i_cfg_data);
                CFG_ARRAY_HEIGHT: r_height <= eff_size(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Pipeline control: a stage loads when empty or when its successor loads.
    logic [NumStages-1:0] r_v;
    logic [NumStages-1:0] rdy;
    logic                 ser_free;
    logic                 r_ser_v;
    logic [1:0]           r_ser_idx;
    logic                 out_last;

    always_comb begin
        rdy[NumStages-1] = !r_v[NumStages-1] || ser_free;
        for (int k = NumStages - 2; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
    end

    assign i_req.ready = rdy[0];

    // Remainder stages
    t_pipe r_pd [ModStages];
    t_pipe n_pd [ModStages];

    always_comb begin
        n_pd[0].chip = i_req.chip_id;
        n_pd[0].core = i_req.core_number;
        n_pd[0].rx   = mod_steps(9'(i_req.chip_id[15:8]) + 9'd1, r_width, 8);
        n_pd[0].ry   = mod_steps(9'(i_req.chip_id[7:0]) + 9'd1, r_height, 8);
        for (int s = 1; s < ModStages; s++) begin
            n_pd[s].chip = r_pd[s-1].chip;
            n_pd[s].core = r_pd[s-1].core;
            n_pd[s].rx   = mod_steps(r_pd[s-1].rx, r_width, 8 - s * StepsPerStage);
            n_pd[s].ry   = mod_steps(r_pd[s-1].ry, r_height, 8 - s * StepsPerStage);
        end
    end

    // Entry build from the last remainder stage
    t_build     n_bd;
    t_build     r_bd;
    t_pipe      s3;
    logic [3:0] pos;
    logic [1:0] x;
    logic [1:0] y;
    logic       ex;
    logic       ey;
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] decx;
    logic [7:0] decy;
    logic [7:0] hx_to;
    logic [7:0] hy_to;
    logic [7:0] hx_from;
    logic [7:0] hy_from;
    t_size      wm1;
    t_size      hm1;
    t_link      link_h;
    t_link      link_v;
    logic [3:0] near_x;
    logic [3:0] near_y;
    logic [15:0] own_cores;
    logic [15:0] row_cores;
    logic [15:0] col_cores;
    logic [15:0] corner_cores;
    t_chip [3:0]  chips;
    t_route [3:0] routes;

    always_comb begin
        s3   = r_pd[ModStages-1];
        pos  = 4'(s3.core - 5'd1);
        x    = pos[1:0];
        y    = pos[3:2];
        ex   = (x == 2'd0) || (x == 2'd3);
        ey   = (y == 2'd0) || (y == 2'd3);
        cx   = s3.chip[15:8];
        cy   = s3.chip[7:0];
        wm1  = r_width - 9'd1;
        hm1  = r_height - 9'd1;
        decx = (cx != 8'd0) ? cx - 8'd1 : wm1[7:0];
        decy = (cy != 8'd0) ? cy - 8'd1 : hm1[7:0];
        // Odd column/row sits at the east/north edge.
        hx_to   = x[0] ? s3.rx[7:0] : decx;
        hy_to   = y[0] ? s3.ry[7:0] : decy;
        hx_from = x[0] ? decx : s3.rx[7:0];
        hy_from = y[0] ? decy : s3.ry[7:0];

        if (r_toroid) begin
            link_h = x[0] ? LINK_E : LINK_W;
            link_v = y[0] ? LINK_N : LINK_S;
        end else begin
            // Pick the link from where the wrapped neighbour really lies.
            link_h = (hx_to == cx) ? LINK_NONE : ((hx_to > cx) ? LINK_E : LINK_W);
            link_v = (hy_to == cy) ? LINK_NONE : ((hy_to > cy) ? LINK_N : LINK_S);
        end

        for (int i = 0; i < 4; i++) begin
            near_x[i] = (i <= int'(x) + 1) && (i + 1 >= int'(x));
            near_y[i] = (i <= int'(y) + 1) && (i + 1 >= int'(y));
        end
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                own_cores[i+4*j]    = near_x[i] && near_y[j]
                                      && !((i == int'(x)) && (j == int'(y)));
                row_cores[i+4*j]    = near_x[i] && (j == 3 - int'(y));
                col_cores[i+4*j]    = (i == 3 - int'(x)) && near_y[j];
                corner_cores[i+4*j] = (i == 3 - int'(x)) && (j == 3 - int'(y));
            end
        end

        routes[0] = {1'b0, own_cores, (ex ? link_h : LINK_NONE) | (ey ? link_v : LINK_NONE)};
        routes[1] = {1'b0, row_cores, (ex ? link_h : LINK_NONE)};
        routes[2] = {1'b0, col_cores, LINK_NONE};
        routes[3] = {1'b0, corner_cores, LINK_NONE};
        chips[0]  = s3.chip;
        chips[1]  = {cx, hy_from};
        chips[2]  = {hx_from, cy};
        chips[3]  = {hx_from, hy_from};

        // Pack present entries in order: an edge-column-only core skips slot 1.
        n_bd.chip[0]  = chips[0];
        n_bd.route[0] = routes[0];
        n_bd.chip[1]  = ey ? chips[1] : chips[2];
        n_bd.route[1] = ey ? routes[1] : routes[2];
        n_bd.chip[2]  = chips[2];
        n_bd.route[2] = routes[2];
        n_bd.chip[3]  = chips[3];
        n_bd.route[3] = routes[3];
        n_bd.core     = s3.core;
        n_bd.cnt      = (ex && ey) ? 2'd3 : ((ex || ey) ? 2'd1 : 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (rdy[0]) begin
                r_v[0] <= i_req.valid;
            end
            for (int k = 1; k < NumStages; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Payload registers hold while their stage stalls.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ModStages; k++) begin
            if (rdy[k]) begin
                r_pd[k] <= n_pd[k];
            end
        end
        if (rdy[NumStages-1]) begin
            r_bd <= n_bd;
        end
    end

    // Output serializer: hand out one entry per response transaction.
    t_build r_ser;

    assign out_last = (r_ser_idx == r_ser.cnt);
    assign ser_free = !r_ser_v || (o_rsp.ready && out_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_v   <= 1'b0;
            r_ser_idx <= 2'd0;
        end else if (ser_free) begin
            r_ser_v   <= r_v[NumStages-1];
            r_ser_idx <= 2'd0;
        end else if (o_rsp.ready) begin
            r_ser_idx <= r_ser_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_free) begin
            r_ser <= r_bd;
        end
    end

    assign o_rsp.valid        = r_ser_v;
    assign o_rsp.source_chip  = r_ser.chip[r_ser_idx];
    assign o_rsp.source_core  = r_ser.core;
    assign o_rsp.route_vector = r_ser.route[r_ser_idx];
    assign o_rsp.last_entry   = out_last;

endmodule
